FILE: sv/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared constants and types of the same-size zero-padded fir correlator.
// ----------------------------------------------------------------------------
package sfc_pkg;

	localparam int MAX_TAPS    = 32;
	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 16;
	localparam int RESULT_BITS = 37;
	localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
	localparam int IDX_W       = $clog2(MAX_TAPS);
	localparam int TAP_W       = $clog2(MAX_TAPS + 1);

	// item codes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// per-cycle commands broadcast along the cell row
	typedef struct packed {
		logic win_shift;   // window moves towards the old end, new value enters cell 0
		logic win_rotate;  // window ring turns towards cell 0
		logic win_clear;   // window cleared at frame end
		logic coef_rotate; // coefficient ring turns towards the last cell
	} cell_ctl_t;

endpackage

FILE: sv/same_size_fir_correlator.sv
// ----------------------------------------------------------------------------
// same_size_fir_correlator
// Same-length zero-padded 1D correlation over a frame of samples, built on a
// row of cells that hold the sample window and the coefficients as two rings.
// ----------------------------------------------------------------------------
//
// channel | direction | handshake           | payload
// --------+-----------+---------------------+-----------------------------------
// in      | input     | in_valid/in_ready   | opcode, tap_index, coefficient_value,
//         |           |                     | sample_value, last_sample
// out     | output    | out_valid/out_ready | result_value, last_result
// cfg     | input     | cfg_valid/cfg_ready | cfg_data (tap_count)
//
// Each output pass turns the coefficient ring 32 - tap_count places into
// line, the single multiply-accumulate then walks tap_count cells, the
// window ring turns the rest of the way back, and the final state hands
// the sum to the output register. A flush adds one zero shift per output
// after the first, and before the first one zero shift for each look-ahead
// sample the frame lacks. Reset gives zero coefficients, an empty window
// and tap_count one. A stalled output holds the row only once the next
// sum is ready.
// ----------------------------------------------------------------------------
module same_size_fir_correlator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   opcode,
	input  logic [sfc_pkg::IDX_W-1:0]              tap_index,
	input  logic signed [sfc_pkg::COEF_BITS-1:0]   coefficient_value,
	input  logic signed [sfc_pkg::SAMPLE_BITS-1:0] sample_value,
	input  logic                                   last_sample,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [sfc_pkg::RESULT_BITS-1:0] result_value,
	output logic                                   last_result,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [sfc_pkg::TAP_W-1:0]              cfg_data
);

	localparam int N   = sfc_pkg::MAX_TAPS;
	localparam int CW  = sfc_pkg::IDX_W;
	localparam int TW  = sfc_pkg::TAP_W;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_ZSHIFT  = 6'b000010,
		ST_ALIGN   = 6'b000100,
		ST_MAC     = 6'b001000,
		ST_RESTORE = 6'b010000,
		ST_FIN     = 6'b100000
	} state_t;

	state_t                                 state_q;
	logic [CW-1:0]                          cnt_q;
	logic [CW:0]                            rem_q;
	logic                                   frame_last_q;
	logic [TW-1:0]                          tc_q;
	logic [TW-1:0]                          seen_q;
	logic                                   out_valid_q;
	logic signed [sfc_pkg::RESULT_BITS-1:0] result_q;
	logic                                   last_q;

	logic [TW-1:0]                          taps;
	logic [TW-1:0]                          half;
	logic [TW-1:0]                          look;
	logic [TW-1:0]                          avail;
	logic [TW-1:0]                          zeros;
	logic [CW-1:0]                          taps_m1;
	logic [CW-1:0]                          pad_m1;
	logic                                   full_kernel;
	logic                                   in_xfer;
	logic                                   load_xfer;
	logic                                   sample_xfer;
	logic                                   out_load;
	logic                                   launch;
	logic                                   mac_clear;
	logic signed [sfc_pkg::SAMPLE_BITS-1:0] shift_val;
	logic signed [sfc_pkg::RESULT_BITS-1:0] mac_sum;
	sfc_pkg::cell_ctl_t                     ctl;
	logic signed [sfc_pkg::SAMPLE_BITS-1:0] win_w  [N];
	logic signed [sfc_pkg::COEF_BITS-1:0]   coef_w [N];

	// tap count in use and derived offsets
	always_comb begin
		if (tc_q == '0) begin
			taps = TW'(1);
		end else if (tc_q > TW'(N)) begin
			taps = TW'(N);
		end else begin
			taps = tc_q;
		end
		half        = taps >> 1;
		look        = taps - TW'(1) - half;
		avail       = (seen_q < look) ? seen_q : look;
		zeros       = look - avail;
		taps_m1     = CW'(taps - TW'(1));
		pad_m1      = CW'(TW'(N) - taps - TW'(1));
		full_kernel = (taps == TW'(N));
	end

	// handshakes
	assign in_ready    = (state_q == ST_IDLE);
	assign cfg_ready   = 1'b1;
	assign in_xfer     = in_valid && in_ready;
	assign load_xfer   = in_xfer && (opcode == sfc_pkg::OP_LOAD);
	assign sample_xfer = in_xfer && (opcode == sfc_pkg::OP_SAMPLE);
	assign out_load    = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// tap count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= TW'(1);
		end else if (cfg_valid && cfg_ready) begin
			tc_q <= cfg_data;
		end
	end

	// start of one output pass
	always_comb begin
		launch = 1'b0;
		case (state_q)
			ST_IDLE: begin
				launch = sample_xfer &&
					((last_sample && zeros == '0) || (!last_sample && seen_q >= look));
			end
			ST_ZSHIFT: begin
				launch = (cnt_q == '0);
			end
			default: begin
				launch = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			rem_q        <= '0;
			frame_last_q <= 1'b0;
			seen_q       <= '0;
		end else begin
			if (sample_xfer && seen_q < TW'(N)) begin
				seen_q <= seen_q + TW'(1);
			end
			if (launch) begin
				state_q <= full_kernel ? ST_MAC : ST_ALIGN;
				cnt_q   <= full_kernel ? taps_m1 : pad_m1;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample_xfer) begin
						frame_last_q <= last_sample;
						rem_q        <= last_sample ? (CW+1)'(avail + TW'(1)) : (CW+1)'(1);
						if (last_sample && zeros != '0) begin
							state_q <= ST_ZSHIFT;
							cnt_q   <= CW'(zeros - TW'(1));
						end
					end
				end
				ST_ZSHIFT: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_ALIGN: begin
					if (cnt_q == '0) begin
						state_q <= ST_MAC;
						cnt_q   <= taps_m1;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_MAC: begin
					if (cnt_q == '0) begin
						state_q <= full_kernel ? ST_FIN : ST_RESTORE;
						cnt_q   <= pad_m1;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_RESTORE: begin
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ST_FIN: begin
					if (out_load) begin
						if (rem_q > (CW+1)'(1)) begin
							rem_q   <= rem_q - (CW+1)'(1);
							state_q <= ST_ZSHIFT;
							cnt_q   <= '0;
						end else begin
							rem_q   <= '0;
							state_q <= ST_IDLE;
							if (frame_last_q) begin
								seen_q <= '0;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// commands to the cell row
	always_comb begin
		ctl.win_shift   = sample_xfer || (state_q == ST_ZSHIFT);
		ctl.win_rotate  = (state_q == ST_MAC) || (state_q == ST_RESTORE);
		ctl.win_clear   = out_load && frame_last_q && (rem_q == (CW+1)'(1));
		ctl.coef_rotate = (state_q == ST_ALIGN) || (state_q == ST_MAC);
		shift_val       = (state_q == ST_ZSHIFT) ? '0 : sample_value;
	end

	// row of cells: window ring turns towards cell 0, coefficients the other way
	for (genvar i = 0; i < N; i++) begin : g_cell
		sfc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.win_up    ((i == 0) ? shift_val : win_w[(i + N - 1) % N]),
			.win_down  (win_w[(i + 1) % N]),
			.coef_prev (coef_w[(i + N - 1) % N]),
			.coef_wr   (load_xfer && (tap_index == CW'(i))),
			.coef_data (coefficient_value),
			.win       (win_w[i]),
			.coef      (coef_w[i])
		);
	end

	// multiply-accumulate fed from the two ends of the row
	assign mac_clear = launch;

	sfc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (mac_clear),
		.issue  (state_q == ST_MAC),
		.sample (win_w[0]),
		.coef   (coef_w[N-1]),
		.sum    (mac_sum)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q <= mac_sum;
			last_q   <= frame_last_q && (rem_q == (CW+1)'(1));
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign last_result  = last_q;

`ifndef SYNTHESIS
	// mac step count never exceeds the kernel
	a_mac_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (cnt_q <= taps_m1))
		else $error("mac step count beyond kernel");

	// a finished sum reaches the output register once there is room
	a_fin_load: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && (!out_valid_q || out_ready)) |=> out_valid)
		else $error("finished sum not delivered");

	// outputs are owed whenever the sequencer is busy
	a_rem_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (rem_q != '0))
		else $error("busy with no output owed");

	// frame end empties the sample count and marks the output
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.win_clear |=> ((seen_q == '0) && out_valid && last_result))
		else $error("frame end not handled");
`endif

endmodule

FILE: sv/sfc_cell.sv
// ----------------------------------------------------------------------------
// sfc_cell
// One cell of the row: holds one window sample and one coefficient, and
// passes both to its neighbours when the rings turn.
// ----------------------------------------------------------------------------
module sfc_cell (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sfc_pkg::cell_ctl_t                     ctl,
	input  logic signed [sfc_pkg::SAMPLE_BITS-1:0] win_up,
	input  logic signed [sfc_pkg::SAMPLE_BITS-1:0] win_down,
	input  logic signed [sfc_pkg::COEF_BITS-1:0]   coef_prev,
	input  logic                                   coef_wr,
	input  logic signed [sfc_pkg::COEF_BITS-1:0]   coef_data,
	output logic signed [sfc_pkg::SAMPLE_BITS-1:0] win,
	output logic signed [sfc_pkg::COEF_BITS-1:0]   coef
);

	logic signed [sfc_pkg::SAMPLE_BITS-1:0] win_q;
	logic signed [sfc_pkg::COEF_BITS-1:0]   coef_q;

	// window sample: shift in, ring turn or frame clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctl.win_clear) begin
			win_q <= '0;
		end else if (ctl.win_shift) begin
			win_q <= win_up;
		end else if (ctl.win_rotate) begin
			win_q <= win_down;
		end
	end

	// coefficient: load or ring turn
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (coef_wr) begin
			coef_q <= coef_data;
		end else if (ctl.coef_rotate) begin
			coef_q <= coef_prev;
		end
	end

	assign win  = win_q;
	assign coef = coef_q;

endmodule

FILE: sv/sfc_mac.sv
// ----------------------------------------------------------------------------
// sfc_mac
// Multiply-accumulate at the end of the cell row: registered product, then
// exact accumulation of one output.
// ----------------------------------------------------------------------------
module sfc_mac (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   clear,
	input  logic                                   issue,
	input  logic signed [sfc_pkg::SAMPLE_BITS-1:0] sample,
	input  logic signed [sfc_pkg::COEF_BITS-1:0]   coef,
	output logic signed [sfc_pkg::RESULT_BITS-1:0] sum
);

	logic signed [sfc_pkg::PROD_BITS-1:0]   prod_s1;
	logic                                   prod_vld_s1;
	logic signed [sfc_pkg::RESULT_BITS-1:0] acc_q;
	logic signed [sfc_pkg::RESULT_BITS-1:0] prod_ext;

	// product stage
	always_ff @(posedge clk) begin
		prod_s1 <= sample * coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= issue;
		end
	end

	assign prod_ext = prod_vld_s1 ?
		sfc_pkg::RESULT_BITS'(prod_s1) : '0;

	// accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clear) begin
			acc_q <= '0;
		end else begin
			acc_q <= acc_q + prod_ext;
		end
	end

	// running total including a product still in flight
	assign sum = acc_q + prod_ext;

endmodule

FILE: sim/sfc_output_checker.sv
// ----------------------------------------------------------------------------
// sfc_output_checker
// Watches the input, output and register channels of the same-size fir
// correlator. It keeps its own copy of the coefficients, the sample window
// and the tap setting, works out the outputs of every accepted item, and
// compares each output transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sfc_output_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic                                   opcode,
	input  logic [sfc_pkg::IDX_W-1:0]              tap_index,
	input  logic signed [sfc_pkg::COEF_BITS-1:0]   coefficient_value,
	input  logic signed [sfc_pkg::SAMPLE_BITS-1:0] sample_value,
	input  logic                                   last_sample,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic signed [sfc_pkg::RESULT_BITS-1:0] result_value,
	input  logic                                   last_result,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [sfc_pkg::TAP_W-1:0]              cfg_data,
	output int                                     outputs_owed,
	output int                                     mismatches
);
	timeunit 1ns;
	timeprecision 1ps;
	import sfc_pkg::*;

	typedef struct packed {
		logic signed [RESULT_BITS-1:0] value;
		logic                          last;
	} filter_out_t;

	logic signed [COEF_BITS-1:0]   coef_bank [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] window [MAX_TAPS];   // newest sample in entry 0
	int                            frame_fill;          // saturates at MAX_TAPS
	logic [TAP_W-1:0]              tap_setting;
	filter_out_t                   owed_q [$];

	// output whose position lies d samples behind the newest one
	function automatic logic signed [RESULT_BITS-1:0] correlate_at(input int d, input int taps,
			input int half);
		longint acc;
		int     j;
		int     k;
		acc = 0;
		for (j = 0; j < taps; j++) begin
			k = d + half - j;
			if (k >= 0 && k < MAX_TAPS)
				acc += longint'(window[k]) * longint'(coef_bank[j]);
		end
		return acc[RESULT_BITS-1:0];
	endfunction

	// follow every transfer on the three channels
	always @(posedge clk or negedge arst_n) begin : track
		filter_out_t want;
		int          added;
		int          taken;
		int          taps;
		int          half;
		int          look;
		int          newest;
		int          d;
		int          i;
		if (!arst_n) begin
			for (i = 0; i < MAX_TAPS; i++) begin
				coef_bank[i] = '0;
				window[i]    = '0;
			end
			frame_fill  = 0;
			tap_setting = TAP_W'(1);
			owed_q.delete();
			mismatches   = 0;
			outputs_owed <= 0;
		end else begin
			added = 0;
			taken = 0;

			// register write
			if (cfg_valid && cfg_ready)
				tap_setting = cfg_data;

			// output transfer against the oldest prediction
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					$error("result_value %0d arrived with no output outstanding", result_value);
					mismatches++;
				end else begin
					want  = owed_q.pop_front();
					taken = 1;
					if (result_value !== want.value) begin
						$error("result_value expected %0d actual %0d", want.value, result_value);
						mismatches++;
					end
					if (last_result !== want.last) begin
						$error("last_result expected %0d actual %0d", want.last, last_result);
						mismatches++;
					end
				end
			end

			// input transfer
			if (in_valid && in_ready) begin
				if (opcode == OP_LOAD) begin
					coef_bank[tap_index] = coefficient_value;
				end else begin
					// zero taps act as one, anything above the row as the full row
					if (tap_setting == 0)
						taps = 1;
					else if (tap_setting > MAX_TAPS)
						taps = MAX_TAPS;
					else
						taps = int'(tap_setting);
					half = taps / 2;
					look = taps - 1 - half;

					for (i = MAX_TAPS - 1; i > 0; i--)
						window[i] = window[i - 1];
					window[0] = sample_value;
					newest    = frame_fill;
					if (frame_fill < MAX_TAPS)
						frame_fill++;

					if (!last_sample) begin
						// one output once the look-ahead has arrived
						if (newest >= look) begin
							want.value = correlate_at(look, taps, half);
							want.last  = 1'b0;
							owed_q.push_back(want);
							added = 1;
						end
					end else begin
						// flush every output still owed, mark the final one, empty the window
						for (d = (newest < look) ? newest : look; d >= 0; d--) begin
							want.value = correlate_at(d, taps, half);
							want.last  = (d == 0);
							owed_q.push_back(want);
							added++;
						end
						for (i = 0; i < MAX_TAPS; i++)
							window[i] = '0;
						frame_fill = 0;
					end
				end
			end

			outputs_owed <= outputs_owed + added - taken;
		end
	end

endmodule

FILE: sim/tb_same_size_fir_correlator.sv
// ----------------------------------------------------------------------------
// tb_same_size_fir_correlator
// Drives coefficient loads, sample frames and tap settings into the
// correlator with random gaps on both channels, two long output hold-offs and
// drained pauses. A directed opening covers the field extremes and the corner
// cases of tap count and frame length; random phases follow. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_same_size_fir_correlator;
	timeunit 1ns;
	timeprecision 1ps;
	import sfc_pkg::*;

	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int SETTLE       = 100;   // longer than one output's trip through the row
	localparam int RANDOM_ITEMS = 300;
	localparam int HOLD_CYCLES  = 600;

	logic                          clk               = 1'b0;
	logic                          arst_n            = 1'b0;
	logic                          in_valid          = 1'b0;
	logic                          in_ready;
	logic                          opcode            = OP_LOAD;
	logic [IDX_W-1:0]              tap_index         = '0;
	logic signed [COEF_BITS-1:0]   coefficient_value = '0;
	logic signed [SAMPLE_BITS-1:0] sample_value      = '0;
	logic                          last_sample       = 1'b0;
	logic                          out_valid;
	logic                          out_ready         = 1'b0;
	logic signed [RESULT_BITS-1:0] result_value;
	logic                          last_result;
	logic                          cfg_valid         = 1'b0;
	logic                          cfg_ready;
	logic [TAP_W-1:0]              cfg_data          = '0;

	int outputs_owed;
	int mismatches;
	int items_sent = 0;
	int cycles     = 0;
	bit tx_calm    = 1'b0;

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	same_size_fir_correlator dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.opcode            (opcode),
		.tap_index         (tap_index),
		.coefficient_value (coefficient_value),
		.sample_value      (sample_value),
		.last_sample       (last_sample),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.result_value      (result_value),
		.last_result       (last_result),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data)
	);

	sfc_output_checker check_i (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.opcode            (opcode),
		.tap_index         (tap_index),
		.coefficient_value (coefficient_value),
		.sample_value      (sample_value),
		.last_sample       (last_sample),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.result_value      (result_value),
		.last_result       (last_result),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.outputs_owed      (outputs_owed),
		.mismatches        (mismatches)
	);

	// field value leaning towards the extremes
	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// one item on the input channel after a random gap
	task automatic offer(input logic op, input logic [IDX_W-1:0] idx,
			input logic [COEF_BITS-1:0] coef, input logic [SAMPLE_BITS-1:0] samp,
			input logic last);
		int gap;
		if ($urandom_range(0, 15) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid          <= 1'b1;
		opcode            <= op;
		tap_index         <= idx;
		coefficient_value <= coef;
		sample_value      <= samp;
		last_sample       <= last;
		do @(posedge clk); while (in_ready !== 1'b1);
		items_sent++;
	endtask

	// coefficient load, sample fields carry noise
	task automatic load_coef(input logic [IDX_W-1:0] idx, input logic [COEF_BITS-1:0] coef);
		offer(OP_LOAD, idx, coef, 16'($urandom), 1'($urandom));
	endtask

	// frame sample, load fields carry noise
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] samp, input logic last);
		offer(OP_SAMPLE, 5'($urandom), 16'($urandom), samp, last);
	endtask

	task automatic send_frame(input int len);
		int k;
		for (k = 0; k < len; k++) begin
			// a stray coefficient load now and then inside the frame
			if ($urandom_range(0, 11) == 0)
				load_coef(5'($urandom), pick_word());
			send_sample(pick_word(), k == len - 1);
		end
	endtask

	// stop offering until every predicted output has been taken
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outputs_owed != 0);
	endtask

	// tap count write once the block has gone quiet
	task automatic set_taps(input int taps);
		drain();
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= TAP_W'(taps);
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	// output side: random stalls, calm stretches and two long hold-offs
	initial begin : receiver
		int gap;
		int taken;
		bit calm;
		taken = 0;
		calm  = 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				calm = !calm;
			gap = calm ? 0 : $urandom_range(0, 14);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			taken++;
			// long hold-off while the sender keeps going, so the block has to hold the sender off
			if (taken == 40 || taken == 160) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	// run limit
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// stimulus and verdict
	initial begin : stimulus
		int random_end;
		int taps_val;
		int eff;
		int loads;
		int frames;
		int frame_len;
		int phase;
		int k;
		int f;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// widest kernel, extreme coefficients, including the last one
		set_taps(MAX_TAPS);
		load_coef(5'd0, 16'h8000);
		load_coef(5'd31, 16'h7FFF);
		load_coef(5'd16, 16'h0001);
		// frame shorter than the kernel, extreme samples
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'h0001, 1'b1);

		// zero taps behave as one; single sample frame
		set_taps(0);
		send_sample(16'h8000, 1'b1);

		// tap count above the row is clamped
		set_taps(63);
		load_coef(5'd5, 16'hFFFF);
		load_coef(5'd30, 16'h8000);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b1);

		// tap count changed in the middle of a frame, load between samples
		set_taps(3);
		send_sample(pick_word(), 1'b0);
		send_sample(pick_word(), 1'b0);
		load_coef(5'd1, 16'h7FFF);
		set_taps(6);
		send_sample(pick_word(), 1'b0);
		send_sample(pick_word(), 1'b0);
		send_sample(pick_word(), 1'b1);

		// random phases: a tap setting, some loads, a few frames
		random_end = items_sent + RANDOM_ITEMS;
		phase      = 0;
		while (items_sent < random_end) begin
			case ($urandom_range(0, 7))
				0: taps_val = 1;
				1: taps_val = MAX_TAPS;
				2: taps_val = 0;
				3: taps_val = $urandom_range(MAX_TAPS + 1, 63);
				default: taps_val = $urandom_range(2, 12);
			endcase
			set_taps(taps_val);
			if (taps_val == 0)
				eff = 1;
			else if (taps_val > MAX_TAPS)
				eff = MAX_TAPS;
			else
				eff = taps_val;

			loads = $urandom_range(0, eff + 2);
			for (k = 0; k < loads; k++) begin
				if ($urandom_range(0, 3) == 0)
					load_coef(5'($urandom), pick_word());
				else
					load_coef(5'($urandom_range(0, eff - 1)), pick_word());
			end

			frames = $urandom_range(1, 4);
			for (f = 0; f < frames; f++) begin
				case ($urandom_range(0, 9))
					0: frame_len = $urandom_range(MAX_TAPS + 1, MAX_TAPS + 8);
					1: frame_len = 1;
					default: frame_len = $urandom_range(1, eff + 4);
				endcase
				send_frame(frame_len);
				// now and then let everything come out before the next frame
				if (f == 0 && phase % 3 == 1)
					drain();
			end
			phase++;
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
